### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define GBR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define GBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gbr_pkg.sv
package gbr_pkg;

    // Fixed field widths
    localparam int BYTE_BITS     = 8;
    localparam int DIMREG_BITS   = 7;
    localparam int SIZE_BITS     = 10;
    localparam int XY_BITS       = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int BIT_CNT_BITS  = 3;
    localparam int UPC_BITS      = 3;
    localparam int OUT_DATA_BITS = 56;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHAR_SIZE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y     = 3'd4;

    // Reset values of the configuration registers
    localparam logic [DIMREG_BITS-1:0] RST_GLYPH_DIM = 7'd8;
    localparam logic [SIZE_BITS-1:0]   RST_CHAR_SIZE = 10'd8;

    // Index of the last pixel of a byte (pixels walk MSB first)
    localparam logic [BIT_CNT_BITS-1:0] PIX_LAST_BIT = 3'd7;

    // Microcode operations
    typedef enum logic [1:0] {
        UOP_FETCH,
        UOP_DIV_START,
        UOP_DIV_WAIT,
        UOP_PIXEL
    } uop_t;

    // Which quotient is being formed: scale step, column offset, row offset
    typedef enum logic [1:0] {
        DSEL_SCALE,
        DSEL_COL,
        DSEL_ROW
    } dsel_t;

    // Jump conditions
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_CLEAN,
        JC_ALWAYS
    } jcond_t;

    typedef struct packed {
        uop_t                op;
        dsel_t               dsel;
        jcond_t              jc;
        logic [UPC_BITS-1:0] target;
    } ucode_t;

    // Program addresses
    localparam logic [UPC_BITS-1:0] UPC_FETCH      = 3'd0;
    localparam logic [UPC_BITS-1:0] UPC_DIV_SCALE  = 3'd1;
    localparam logic [UPC_BITS-1:0] UPC_WAIT_SCALE = 3'd2;
    localparam logic [UPC_BITS-1:0] UPC_DIV_COL    = 3'd3;
    localparam logic [UPC_BITS-1:0] UPC_WAIT_COL   = 3'd4;
    localparam logic [UPC_BITS-1:0] UPC_DIV_ROW    = 3'd5;
    localparam logic [UPC_BITS-1:0] UPC_WAIT_ROW   = 3'd6;
    localparam logic [UPC_BITS-1:0] UPC_PIXEL      = 3'd7;

    // Control store. A clean scale skips the three divisions.
    function automatic ucode_t ucode_rom(input logic [UPC_BITS-1:0] addr);
        ucode_t uw;
        case (addr)
            UPC_FETCH:      uw = '{UOP_FETCH,     DSEL_SCALE, JC_CLEAN,  UPC_PIXEL};
            UPC_DIV_SCALE:  uw = '{UOP_DIV_START, DSEL_SCALE, JC_NEXT,   UPC_FETCH};
            UPC_WAIT_SCALE: uw = '{UOP_DIV_WAIT,  DSEL_SCALE, JC_NEXT,   UPC_FETCH};
            UPC_DIV_COL:    uw = '{UOP_DIV_START, DSEL_COL,   JC_NEXT,   UPC_FETCH};
            UPC_WAIT_COL:   uw = '{UOP_DIV_WAIT,  DSEL_COL,   JC_NEXT,   UPC_FETCH};
            UPC_DIV_ROW:    uw = '{UOP_DIV_START, DSEL_ROW,   JC_NEXT,   UPC_FETCH};
            UPC_WAIT_ROW:   uw = '{UOP_DIV_WAIT,  DSEL_ROW,   JC_NEXT,   UPC_FETCH};
            UPC_PIXEL:      uw = '{UOP_PIXEL,     DSEL_SCALE, JC_ALWAYS, UPC_FETCH};
            default:        uw = '{UOP_FETCH,     DSEL_SCALE, JC_ALWAYS, UPC_FETCH};
        endcase
        return uw;
    endfunction

endpackage

### hw/rtl/gbr_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module gbr_div #(
    parameter int DVD_BITS = 17,
    parameter int DVS_BITS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                busy,
    output logic [DVD_BITS-1:0] quotient,
    output logic [DVS_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DVD_BITS-1:0] quo_reg;
    logic [DVS_BITS-1:0] rem_reg;
    logic [DVS_BITS-1:0] dvs_reg;

    logic [DVS_BITS:0]   trial;
    logic                fits;
    logic [DVS_BITS:0]   trial_sub;

    // One shift-subtract step
    assign trial     = {rem_reg, quo_reg[DVD_BITS-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_BITS'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= CNT_BITS'(DVD_BITS);
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_BITS-2:0], fits};
            rem_reg <= fits ? trial_sub[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/glyph_bitmap_to_rects.sv
// Glyph bitmap to scaled rectangles.
// Slave stream: one packed bitmap byte per word, bit 7 is the first pixel;
// tuser set restarts the glyph at column 0, row 0 before the byte is used.
// Master stream: one filled rectangle per set pixel inside the glyph; tlast
// marks the final rectangle caused by a byte. Bytes with no set pixel in
// range produce no word.
// Config channel: register writes, taken only while the sequencer waits for
// a byte and no byte is offered. Changing glyph_height or char_size marks
// the scale stale.
// Steps: each byte is fetched, then its eight pixels are walked MSB first; a
// byte past the end of the glyph ends the walk at once. The first byte after
// reset or after a height/size write first runs three serial divisions.
// A rectangle is held one stage until the next one or the end of its byte
// is known, then sits in the output register until taken.
// Reset: registers return to 8x8 glyph, size 8, origin 0, counters clear.
// A stalled receiver holds the pixel walk on the next set pixel; a
// config write never stalls the datapath.
`include "assert_macros.svh"

module glyph_bitmap_to_rects #(
    parameter int MAX_GLYPH_DIM = 64,
    parameter int COORD_BITS    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // bitmap_byte[7:0]
    input  logic [gbr_pkg::BYTE_BITS-1:0]       s_tdata,
    // glyph_start
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rect_x[15:0], rect_y[31:16], rect_w[41:32], rect_h[51:42], zero pad
    output logic [gbr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // last_of_byte
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gbr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [gbr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int DIMREG_BITS = gbr_pkg::DIMREG_BITS;
    localparam int SIZE_BITS   = gbr_pkg::SIZE_BITS;
    localparam int XY_BITS     = gbr_pkg::XY_BITS;
    localparam int DIM_BITS    = $clog2(MAX_GLYPH_DIM + 1);
    localparam int CLP_BITS    = (DIM_BITS > DIMREG_BITS) ? DIM_BITS : DIMREG_BITS;
    localparam int DVD_BITS    = DIM_BITS + SIZE_BITS;
    localparam int SUM_A       = (COORD_BITS > DVD_BITS) ? COORD_BITS : DVD_BITS;
    localparam int SUM_BITS    = ((SUM_A > XY_BITS) ? SUM_A : XY_BITS) + 2;
    localparam int PAD_BITS    = gbr_pkg::OUT_DATA_BITS - 2 * XY_BITS - 2 * SIZE_BITS;

    localparam logic [CLP_BITS-1:0] MAX_DIM_C = CLP_BITS'(MAX_GLYPH_DIM);
    localparam logic signed [SUM_BITS-1:0] COORD_HI =
        SUM_BITS'((longint'(1) << (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] COORD_LO =
        SUM_BITS'(-(longint'(1) << (COORD_BITS - 1)));

    // Configuration registers
    logic [DIMREG_BITS-1:0] width_cfg_reg;
    logic [DIMREG_BITS-1:0] height_cfg_reg;
    logic [SIZE_BITS-1:0]   size_reg;
    logic [XY_BITS-1:0]     origin_x_reg;
    logic [XY_BITS-1:0]     origin_y_reg;
    logic                   dirty_reg;

    // Sequencer
    logic [gbr_pkg::UPC_BITS-1:0] upc_reg;
    logic [gbr_pkg::UPC_BITS-1:0] upc_next;
    gbr_pkg::ucode_t              uc;
    logic                         step_done;
    logic                         jump_taken;

    // Walk state
    logic [DIM_BITS-1:0]               col_reg;
    logic [DIM_BITS-1:0]               row_reg;
    logic [gbr_pkg::BYTE_BITS-1:0]     byte_reg;
    logic [gbr_pkg::BIT_CNT_BITS-1:0]  bitcnt_reg;
    logic [DVD_BITS-1:0]               xq_reg;
    logic [DIM_BITS-1:0]               xr_reg;
    logic [DVD_BITS-1:0]               yq_reg;
    logic [DIM_BITS-1:0]               yr_reg;
    logic [SIZE_BITS-1:0]              sq_reg;
    logic [DIM_BITS-1:0]               sr_reg;

    // Hold stage and output register
    logic                   pend_valid_reg;
    logic [XY_BITS-1:0]     pend_x_reg;
    logic [XY_BITS-1:0]     pend_y_reg;
    logic [SIZE_BITS-1:0]   pend_w_reg;
    logic [SIZE_BITS-1:0]   pend_h_reg;
    logic                   m_tvalid_reg;
    logic                   m_tlast_reg;
    logic [XY_BITS-1:0]     m_x_reg;
    logic [XY_BITS-1:0]     m_y_reg;
    logic [SIZE_BITS-1:0]   m_w_reg;
    logic [SIZE_BITS-1:0]   m_h_reg;

    // Combinational control
    logic s_tready_int;
    logic s_accept;
    logic out_free;
    logic div_start;
    logic push_out;
    logic push_last;
    logic load_pend;
    logic adv;
    logic in_range;

    // Divider
    logic [DVD_BITS-1:0] div_dividend;
    logic                div_busy;
    logic [DVD_BITS-1:0] div_quo;
    logic [DIM_BITS-1:0] div_rem;

    // Pixel math
    logic [DIM_BITS-1:0] w_eff;
    logic [DIM_BITS-1:0] h_eff;
    logic [DIM_BITS:0]   col_inc;
    logic                col_wrap;
    logic [DIM_BITS:0]   xr_sum;
    logic [DIM_BITS:0]   yr_sum;
    logic                x_carry;
    logic                y_carry;
    logic [DIM_BITS:0]   xr_sub;
    logic [DIM_BITS:0]   yr_sub;
    logic [DIM_BITS-1:0] xr_adv;
    logic [DIM_BITS-1:0] yr_adv;
    logic [DVD_BITS-1:0] xq_adv;
    logic [DVD_BITS-1:0] yq_adv;
    logic [SIZE_BITS:0]  rect_w_c;
    logic [SIZE_BITS:0]  rect_h_c;
    logic signed [SUM_BITS-1:0] x_sum;
    logic signed [SUM_BITS-1:0] y_sum;
    logic signed [SUM_BITS-1:0] x_sat;
    logic signed [SUM_BITS-1:0] y_sat;

    // Clamp a raw dimension to 1..MAX_GLYPH_DIM
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = DIM_BITS'(1);
        end else if (CLP_BITS'(width_cfg_reg) > MAX_DIM_C) begin
            w_eff = DIM_BITS'(MAX_GLYPH_DIM);
        end else begin
            w_eff = DIM_BITS'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = DIM_BITS'(1);
        end else if (CLP_BITS'(height_cfg_reg) > MAX_DIM_C) begin
            h_eff = DIM_BITS'(MAX_GLYPH_DIM);
        end else begin
            h_eff = DIM_BITS'(height_cfg_reg);
        end
    end

    // Column and row offsets advance by size/h: quotient sq plus carry of remainder
    assign col_inc  = {1'b0, col_reg} + (DIM_BITS + 1)'(1);
    assign col_wrap = col_inc >= {1'b0, w_eff};
    assign xr_sum   = {1'b0, xr_reg} + {1'b0, sr_reg};
    assign yr_sum   = {1'b0, yr_reg} + {1'b0, sr_reg};
    assign x_carry  = xr_sum >= {1'b0, h_eff};
    assign y_carry  = yr_sum >= {1'b0, h_eff};
    assign xr_sub   = xr_sum - {1'b0, h_eff};
    assign yr_sub   = yr_sum - {1'b0, h_eff};
    assign xr_adv   = x_carry ? xr_sub[DIM_BITS-1:0] : xr_sum[DIM_BITS-1:0];
    assign yr_adv   = y_carry ? yr_sub[DIM_BITS-1:0] : yr_sum[DIM_BITS-1:0];
    assign xq_adv   = xq_reg + DVD_BITS'(sq_reg) + DVD_BITS'(x_carry);
    assign yq_adv   = yq_reg + DVD_BITS'(sq_reg) + DVD_BITS'(y_carry);
    assign rect_w_c = {1'b0, sq_reg} + (SIZE_BITS + 1)'(x_carry);
    assign rect_h_c = {1'b0, sq_reg} + (SIZE_BITS + 1)'(y_carry);
    assign in_range = row_reg < h_eff;

    // Screen coordinates with saturation
    assign x_sum = $signed({{(SUM_BITS - XY_BITS){origin_x_reg[XY_BITS-1]}}, origin_x_reg})
                 + $signed({{(SUM_BITS - DVD_BITS){1'b0}}, xq_reg});
    assign y_sum = $signed({{(SUM_BITS - XY_BITS){origin_y_reg[XY_BITS-1]}}, origin_y_reg})
                 + $signed({{(SUM_BITS - DVD_BITS){1'b0}}, yq_reg});
    assign x_sat = (x_sum > COORD_HI) ? COORD_HI : ((x_sum < COORD_LO) ? COORD_LO : x_sum);
    assign y_sat = (y_sum > COORD_HI) ? COORD_HI : ((y_sum < COORD_LO) ? COORD_LO : y_sum);

    // Dividend select for the current microcode word
    always_comb begin
        case (uc.dsel)
            gbr_pkg::DSEL_SCALE: div_dividend = DVD_BITS'(size_reg);
            gbr_pkg::DSEL_COL:   div_dividend = DVD_BITS'(col_reg) * DVD_BITS'(size_reg);
            gbr_pkg::DSEL_ROW:   div_dividend = DVD_BITS'(row_reg) * DVD_BITS'(size_reg);
            default:             div_dividend = '0;
        endcase
    end

    gbr_div #(
        .DVD_BITS (DVD_BITS),
        .DVS_BITS (DIM_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (h_eff),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Control word decode
    assign uc       = gbr_pkg::ucode_rom(upc_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready_int;

    always_comb begin
        s_tready_int = 1'b0;
        div_start    = 1'b0;
        step_done    = 1'b0;
        push_out     = 1'b0;
        push_last    = 1'b0;
        load_pend    = 1'b0;
        adv          = 1'b0;
        case (uc.op)
            gbr_pkg::UOP_FETCH: begin
                // flush the held rectangle as the byte's last
                s_tready_int = !pend_valid_reg || out_free;
                push_out     = pend_valid_reg && out_free;
                push_last    = 1'b1;
                step_done    = s_tvalid && s_tready_int;
            end
            gbr_pkg::UOP_DIV_START: begin
                div_start = 1'b1;
                step_done = 1'b1;
            end
            gbr_pkg::UOP_DIV_WAIT: begin
                step_done = !div_busy;
            end
            gbr_pkg::UOP_PIXEL: begin
                if (!in_range) begin
                    step_done = 1'b1;
                end else if (!(byte_reg[gbr_pkg::BYTE_BITS-1] && pend_valid_reg && !out_free)) begin
                    adv       = 1'b1;
                    load_pend = byte_reg[gbr_pkg::BYTE_BITS-1];
                    push_out  = byte_reg[gbr_pkg::BYTE_BITS-1] && pend_valid_reg;
                    step_done = bitcnt_reg == gbr_pkg::PIX_LAST_BIT;
                end
            end
            default: ;
        endcase
    end

    // Next microcode address
    always_comb begin
        case (uc.jc)
            gbr_pkg::JC_ALWAYS: jump_taken = 1'b1;
            gbr_pkg::JC_CLEAN:  jump_taken = !dirty_reg;
            default:            jump_taken = 1'b0;
        endcase
        if (!step_done) begin
            upc_next = upc_reg;
        end else if (jump_taken) begin
            upc_next = uc.target;
        end else begin
            upc_next = upc_reg + gbr_pkg::UPC_BITS'(1);
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg        <= gbr_pkg::UPC_FETCH;
            dirty_reg      <= 1'b1;
            width_cfg_reg  <= gbr_pkg::RST_GLYPH_DIM;
            height_cfg_reg <= gbr_pkg::RST_GLYPH_DIM;
            size_reg       <= gbr_pkg::RST_CHAR_SIZE;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            upc_reg <= upc_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gbr_pkg::CFG_GLYPH_WIDTH: begin
                        width_cfg_reg <= cfg_data[DIMREG_BITS-1:0];
                    end
                    gbr_pkg::CFG_GLYPH_HEIGHT: begin
                        height_cfg_reg <= cfg_data[DIMREG_BITS-1:0];
                        dirty_reg      <= 1'b1;
                    end
                    gbr_pkg::CFG_CHAR_SIZE: begin
                        size_reg  <= cfg_data[SIZE_BITS-1:0];
                        dirty_reg <= 1'b1;
                    end
                    gbr_pkg::CFG_ORIGIN_X: begin
                        origin_x_reg <= cfg_data[XY_BITS-1:0];
                    end
                    gbr_pkg::CFG_ORIGIN_Y: begin
                        origin_y_reg <= cfg_data[XY_BITS-1:0];
                    end
                    default: ;
                endcase
            end

            if (uc.op == gbr_pkg::UOP_DIV_WAIT && !div_busy && uc.dsel == gbr_pkg::DSEL_ROW) begin
                dirty_reg <= 1'b0;
            end

            // Source position
            if (s_accept && s_tuser) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (adv) begin
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_reg + DIM_BITS'(1);
                end else begin
                    col_reg <= col_inc[DIM_BITS-1:0];
                end
            end

            if (load_pend) begin
                pend_valid_reg <= 1'b1;
            end else if (push_out) begin
                pend_valid_reg <= 1'b0;
            end

            if (push_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg   <= s_tdata;
            bitcnt_reg <= '0;
            if (s_tuser) begin
                xq_reg <= '0;
                xr_reg <= '0;
                yq_reg <= '0;
                yr_reg <= '0;
            end
        end else if (adv) begin
            byte_reg   <= {byte_reg[gbr_pkg::BYTE_BITS-2:0], 1'b0};
            bitcnt_reg <= bitcnt_reg + gbr_pkg::BIT_CNT_BITS'(1);
            if (col_wrap) begin
                xq_reg <= '0;
                xr_reg <= '0;
                yq_reg <= yq_adv;
                yr_reg <= yr_adv;
            end else begin
                xq_reg <= xq_adv;
                xr_reg <= xr_adv;
            end
        end

        // Division results
        if (uc.op == gbr_pkg::UOP_DIV_WAIT && !div_busy) begin
            case (uc.dsel)
                gbr_pkg::DSEL_SCALE: begin
                    sq_reg <= div_quo[SIZE_BITS-1:0];
                    sr_reg <= div_rem;
                end
                gbr_pkg::DSEL_COL: begin
                    xq_reg <= div_quo;
                    xr_reg <= div_rem;
                end
                gbr_pkg::DSEL_ROW: begin
                    yq_reg <= div_quo;
                    yr_reg <= div_rem;
                end
                default: ;
            endcase
        end

        if (load_pend) begin
            pend_x_reg <= x_sat[XY_BITS-1:0];
            pend_y_reg <= y_sat[XY_BITS-1:0];
            pend_w_reg <= rect_w_c[SIZE_BITS-1:0];
            pend_h_reg <= rect_h_c[SIZE_BITS-1:0];
        end

        if (push_out) begin
            m_x_reg     <= pend_x_reg;
            m_y_reg     <= pend_y_reg;
            m_w_reg     <= pend_w_reg;
            m_h_reg     <= pend_h_reg;
            m_tlast_reg <= push_last;
        end
    end

    assign s_tready  = s_tready_int;
    // a byte on offer goes first, so a write never slips in beside it
    assign cfg_ready = (uc.op == gbr_pkg::UOP_FETCH) && !s_tvalid;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tdata   = {{PAD_BITS{1'b0}}, m_h_reg, m_w_reg, m_y_reg, m_x_reg};

    // Assertions
    `GBR_ASSERT_IMPL(a_div_idle_start, uc.op == gbr_pkg::UOP_DIV_START, !div_busy,
        "divider started while busy")
    `GBR_ASSERT_IMPL(a_rem_in_range, uc.op == gbr_pkg::UOP_PIXEL,
        (xr_reg < h_eff) && (yr_reg < h_eff) && (sr_reg < h_eff),
        "scale remainder not below glyph height")
    `GBR_ASSERT_NEXT(a_stale_rescale, s_accept && dirty_reg,
        upc_reg == gbr_pkg::UPC_DIV_SCALE, "stale scale not recomputed")
    `GBR_ASSERT_NEXT(a_flush_on_fetch, s_accept && pend_valid_reg, !pend_valid_reg,
        "held rectangle not flushed at byte fetch")

endmodule

### sim/gbr_rect_checker.sv
`timescale 1ns / 100ps

// Watches the bitmap, rectangle and register channels of the rasterizer.
// Keeps its own copy of the registers and of the column/row walk, predicts
// the rectangles of every accepted bitmap word and compares each rectangle
// word against the oldest one still expected.
module gbr_rect_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [gbr_pkg::BYTE_BITS-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [gbr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                m_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [gbr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [gbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  mismatch_count,
    output int                                  rects_pending
);

    localparam int     GLYPH_DIM_MAX = 64;
    localparam longint COORD_HI      = 32767;
    localparam longint COORD_LO      = -32768;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [9:0]  w;
        logic [9:0]  h;
        logic        last;
    } rect_t;

    rect_t expected_rects[$];

    // register mirror
    logic [gbr_pkg::DIMREG_BITS-1:0] width_reg;
    logic [gbr_pkg::DIMREG_BITS-1:0] height_reg;
    logic [gbr_pkg::SIZE_BITS-1:0]   size_reg;
    logic [15:0]                     org_x;
    logic [15:0]                     org_y;

    // pixel walk position
    int unsigned col_pos;
    int unsigned row_pos;

    // 0 counts as 1, anything past the maximum as the maximum
    function automatic int unsigned dim_in_use(input logic [gbr_pkg::DIMREG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > GLYPH_DIM_MAX)
            return GLYPH_DIM_MAX;
        return v;
    endfunction

    // origin plus scaled offset, saturated to 16 bits signed
    function automatic logic [15:0] place(input logic [15:0] org, input int unsigned offs);
        longint v;
        v = longint'($signed(org)) + longint'(offs);
        if (v > COORD_HI)
            v = COORD_HI;
        if (v < COORD_LO)
            v = COORD_LO;
        return v[15:0];
    endfunction

    // Walk the eight pixels MSB first; one rectangle per set pixel in range.
    // The last rectangle of a byte is held back so it can carry tlast.
    task automatic predict_byte(input logic [7:0] pix, input logic restart);
        int unsigned wd;
        int unsigned ht;
        int unsigned sx0;
        int unsigned sx1;
        int unsigned sy0;
        int unsigned sy1;
        rect_t       held;
        logic        have_held;
        wd        = dim_in_use(width_reg);
        ht        = dim_in_use(height_reg);
        have_held = 1'b0;
        held      = '0;
        if (restart) begin
            col_pos = 0;
            row_pos = 0;
        end
        for (int b = 7; b >= 0; b--) begin
            if (row_pos >= ht)
                break;
            if (pix[b]) begin
                if (have_held)
                    expected_rects.push_back(held);
                sx0       = (col_pos * size_reg) / ht;
                sx1       = ((col_pos + 1) * size_reg) / ht;
                sy0       = (row_pos * size_reg) / ht;
                sy1       = ((row_pos + 1) * size_reg) / ht;
                held.x    = place(org_x, sx0);
                held.y    = place(org_y, sy0);
                held.w    = 10'(sx1 - sx0);
                held.h    = 10'(sy1 - sy0);
                held.last = 1'b0;
                have_held = 1'b1;
            end
            col_pos++;
            if (col_pos >= wd) begin
                col_pos = 0;
                row_pos++;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_rects.push_back(held);
        end
    endtask

    task automatic check_rect(input logic [gbr_pkg::OUT_DATA_BITS-1:0] word, input logic lst);
        rect_t got;
        rect_t want;
        got.x    = word[15:0];
        got.y    = word[31:16];
        got.w    = word[41:32];
        got.h    = word[51:42];
        got.last = lst;
        if (expected_rects.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t checker: unexpected rect x=%0d y=%0d w=%0d h=%0d last=%0b",
                         $realtime, $signed(got.x), $signed(got.y), got.w, got.h, got.last);
        end else begin
            want = expected_rects.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                got.h !== want.h || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"%0t checker: rect mismatch, exp x=%0d y=%0d w=%0d h=%0d ",
                              "last=%0b, got x=%0d y=%0d w=%0d h=%0d last=%0b"},
                             $realtime, $signed(want.x), $signed(want.y), want.w, want.h,
                             want.last, $signed(got.x), $signed(got.y), got.w, got.h,
                             got.last);
            end
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      = gbr_pkg::RST_GLYPH_DIM;
            height_reg     = gbr_pkg::RST_GLYPH_DIM;
            size_reg       = gbr_pkg::RST_CHAR_SIZE;
            org_x          = '0;
            org_y          = '0;
            col_pos        = 0;
            row_pos        = 0;
            mismatch_count = 0;
            expected_rects.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_rect(m_tdata, m_tlast);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gbr_pkg::CFG_GLYPH_WIDTH:  width_reg  = cfg_data[gbr_pkg::DIMREG_BITS-1:0];
                    gbr_pkg::CFG_GLYPH_HEIGHT: height_reg = cfg_data[gbr_pkg::DIMREG_BITS-1:0];
                    gbr_pkg::CFG_CHAR_SIZE:    size_reg   = cfg_data[gbr_pkg::SIZE_BITS-1:0];
                    gbr_pkg::CFG_ORIGIN_X:     org_x      = cfg_data;
                    gbr_pkg::CFG_ORIGIN_Y:     org_y      = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tuser);
        end
        rects_pending = expected_rects.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_PAUSE   = 200;
    localparam int RANDOM_BYTES  = 480;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int GLYPH_DIM_MAX = 64;
    localparam int MAX_GLYPH_BITS = 512;

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;
    // shapes of a random bitmap sequence
    typedef enum int {SEQ_WHOLE, SEQ_BROKEN, SEQ_NOISE, SEQ_CUT} seq_kind_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic [gbr_pkg::BYTE_BITS-1:0]       s_tdata   = '0;
    logic                                s_tuser   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    wire                                 s_tready;
    wire  [gbr_pkg::OUT_DATA_BITS-1:0]   m_tdata;
    wire                                 m_tlast;
    wire                                 m_tvalid;
    logic                                m_tready  = 1'b0;
    logic                                cfg_valid = 1'b0;
    wire                                 cfg_ready;
    logic [gbr_pkg::CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [gbr_pkg::CFG_DATA_BITS-1:0]   cfg_data  = '0;

    int mismatch_count;
    int rects_pending;
    int cycle_count = 0;
    int burst_left  = 0;

    // widths last written, to size the glyph sequences
    logic [gbr_pkg::DIMREG_BITS-1:0] width_set  = gbr_pkg::RST_GLYPH_DIM;
    logic [gbr_pkg::DIMREG_BITS-1:0] height_set = gbr_pkg::RST_GLYPH_DIM;

    glyph_bitmap_to_rects i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gbr_rect_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .rects_pending  (rects_pending)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver: switches between randomly chosen stall patterns
    rx_mode_t   stall_mode = RX_OPEN;
    int         stall_left = 0;
    logic [7:0] stall_tick = '0;

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (stall_tick[1:0] == 2'd0);
            default:   m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic int dim_in_use(input logic [gbr_pkg::DIMREG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > GLYPH_DIM_MAX)
            return GLYPH_DIM_MAX;
        return v;
    endfunction

    // words in one whole glyph at the current size
    function automatic int glyph_word_count();
        return (dim_in_use(width_set) * dim_in_use(height_set) + 7) / 8;
    endfunction

    function automatic logic [7:0] rand_pixels();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One bitmap word; the sender runs in bursts with random gaps between
    task automatic push_bitmap_word(input logic [7:0] pix, input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Stop sending and wait until every rectangle has come out
    task automatic drain_rects();
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (rects_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [gbr_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [gbr_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == gbr_pkg::CFG_GLYPH_WIDTH)
            width_set = value[gbr_pkg::DIMREG_BITS-1:0];
        if (idx == gbr_pkg::CFG_GLYPH_HEIGHT)
            height_set = value[gbr_pkg::DIMREG_BITS-1:0];
    endtask

    task automatic apply_setting(input int w, input int h, input int sz,
                                 input int ox, input int oy);
        write_reg(gbr_pkg::CFG_GLYPH_WIDTH,  16'(w));
        write_reg(gbr_pkg::CFG_GLYPH_HEIGHT, 16'(h));
        write_reg(gbr_pkg::CFG_CHAR_SIZE,    16'(sz));
        write_reg(gbr_pkg::CFG_ORIGIN_X,     16'(ox));
        write_reg(gbr_pkg::CFG_ORIGIN_Y,     16'(oy));
    endtask

    function automatic logic [6:0] rand_dim();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(65, 127));
            1:       return 7'd64;
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] rand_origin();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    // New random setting; width, height and size written with junk in unused bits.
    // Large glyphs are trimmed so one glyph stays within 512 pixels, 64 words.
    task automatic pick_random_setting();
        logic [6:0] w;
        logic [6:0] h;
        logic [9:0] sz;
        logic       wr_w;
        logic       wr_h;
        w    = rand_dim();
        h    = rand_dim();
        wr_w = ($urandom_range(0, 3) != 0);
        wr_h = ($urandom_range(0, 3) != 0);
        // a skipped write keeps the size already in the block
        if (!wr_w)
            w = width_set;
        if (!wr_h)
            h = height_set;
        if (dim_in_use(w) * dim_in_use(h) > MAX_GLYPH_BITS) begin
            h    = 7'(MAX_GLYPH_BITS / dim_in_use(w));
            wr_h = 1'b1;
        end
        case ($urandom_range(0, 5))
            0:       sz = 10'd0;
            1:       sz = 10'd1023;
            2:       sz = 10'($urandom_range(1, 8));
            default: sz = 10'($urandom);
        endcase
        if (wr_w)
            write_reg(gbr_pkg::CFG_GLYPH_WIDTH,  {9'($urandom), w});
        if (wr_h)
            write_reg(gbr_pkg::CFG_GLYPH_HEIGHT, {9'($urandom), h});
        if ($urandom_range(0, 3) != 0)
            write_reg(gbr_pkg::CFG_CHAR_SIZE,    {6'($urandom), sz});
        if ($urandom_range(0, 3) != 0)
            write_reg(gbr_pkg::CFG_ORIGIN_X,     rand_origin());
        if ($urandom_range(0, 3) != 0)
            write_reg(gbr_pkg::CFG_ORIGIN_Y,     rand_origin());
    endtask

    // Mostly whole glyphs with random pixels; some broken, cut short or noise
    task automatic run_glyph_phase(output int counted);
        int        target;
        int        n;
        int        k;
        seq_kind_t kind;
        int        pick;
        counted = 0;
        target  = $urandom_range(20, 60);
        while (counted < target) begin
            n    = glyph_word_count();
            pick = $urandom_range(0, 9);
            kind = (pick < 7) ? SEQ_WHOLE : (pick == 7) ? SEQ_BROKEN :
                   (pick == 8) ? SEQ_NOISE : SEQ_CUT;
            case (kind)
                SEQ_WHOLE: begin
                    for (int i = 0; i < n; i++)
                        push_bitmap_word(rand_pixels(), i == 0);
                    counted += n;
                end
                SEQ_BROKEN: begin
                    k = $urandom_range(1, n);
                    for (int i = 0; i < k; i++)
                        push_bitmap_word(rand_pixels(), $urandom_range(0, 7) == 0);
                    counted += k;
                end
                SEQ_NOISE: begin
                    k = $urandom_range(1, 3);
                    for (int i = 0; i < k; i++)
                        push_bitmap_word(rand_pixels(), 1'b0);
                    counted += k;
                end
                default: begin
                    k = $urandom_range(1, n);
                    for (int i = 0; i < k; i++)
                        push_bitmap_word(rand_pixels(), i == 0);
                    counted += k;
                end
            endcase
        end
    endtask

    initial begin
        int live_words;
        int phase_words;
        live_words = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default 8x8 glyph: full glyph, then a word past its end, then restart
        push_bitmap_word(8'hFF, 1'b1);
        push_bitmap_word(8'h00, 1'b0);
        push_bitmap_word(8'h81, 1'b0);
        push_bitmap_word(8'hAA, 1'b0);
        push_bitmap_word(8'h55, 1'b0);
        push_bitmap_word(8'h01, 1'b0);
        push_bitmap_word(8'h80, 1'b0);
        push_bitmap_word(8'hFF, 1'b0);
        push_bitmap_word(8'hFF, 1'b0);
        push_bitmap_word(8'h3C, 1'b1);
        drain_rects();

        // zero width taken as one; y saturates high, x starts at the minimum
        apply_setting(0, 3, 5, -32768, 32767);
        push_bitmap_word(8'hFF, 1'b1);
        push_bitmap_word(8'hFF, 1'b0);
        drain_rects();

        // oversized width clamps to 64, largest size, x saturates
        apply_setting(127, 1, 1023, 32767, -32768);
        push_bitmap_word(8'hFF, 1'b1);
        push_bitmap_word(8'h7E, 1'b0);
        drain_rects();

        // zero size: every rectangle empty at the origin
        apply_setting(64, 64, 0, 1234, -4321);
        push_bitmap_word(8'hA5, 1'b1);
        push_bitmap_word(8'hFF, 1'b0);
        drain_rects();

        // zero height taken as one: five pixels, rest of the byte ignored
        apply_setting(5, 0, 1, 100, 200);
        push_bitmap_word(8'hFF, 1'b1);
        push_bitmap_word(8'hFF, 1'b0);
        drain_rects();

        // tall narrow glyph with downscaling gives zero-sized rectangles
        apply_setting(1, 64, 2, -1000, -32768);
        push_bitmap_word(8'hFF, 1'b1);
        push_bitmap_word(8'hFF, 1'b0);
        push_bitmap_word(8'h0F, 1'b0);
        drain_rects();

        // random settings, each followed by a stream of glyphs
        while (live_words < RANDOM_BYTES) begin
            pick_random_setting();
            run_glyph_phase(phase_words);
            live_words += phase_words;
            drain_rects();
        end

        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
